[sv/rsi_pkg.sv]
package rsi_pkg;

    // Q(31-FRAC_BITS).FRAC_BITS distances and coordinates
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 31;
    localparam int OC_W    = COORD_W + 1;
    localparam int LO_W    = 32;

    // quadratic terms, exact
    localparam int A_W    = 64;
    localparam int H_W    = 66;
    localparam int HABS_W = H_W - 1;
    localparam int HH_W   = HABS_W - LO_W;
    localparam int C_W    = 67;
    localparam int CABS_W = C_W - 1;
    localparam int CH_W   = CABS_W - LO_W;
    localparam int P_W    = 130;
    localparam int Q_W    = P_W + 2;

    // square root
    localparam int S_W      = Q_W / 2;
    localparam int SR_W     = S_W + 2;
    localparam int SQ_STEPS = S_W;

    // root numerators and the divider
    localparam int NA_W      = A_W + DIST_W;
    localparam int N_W       = S_W + 2;
    localparam int X_W       = N_W - 1 + FRAC_BITS;
    localparam int REM_W     = A_W + DIST_W + 1;
    localparam int DIV_STEPS = DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic                    ok;
        logic signed [H_W-1:0]   h;
        logic [A_W-1:0]          a;
        logic [NA_W-1:0]         na;
        logic [DIST_W-1:0]       near;
    } t_sq_side;

    typedef struct packed {
        logic                hit;
        logic [DIST_W-1:0]   near;
    } t_dv_side;

endpackage

[sv/rsi_isqrt.sv]
module rsi_isqrt
    import rsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [Q_W-1:0]    i_q,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [S_W-1:0]    o_s,
    output t_sq_side          o_side
);

    // one root bit per stage, radicand consumed two bits at a time from the top
    logic [SR_W-1:0] w_rem  [SQ_STEPS];
    logic [Q_W-1:0]  w_x    [SQ_STEPS];
    logic [S_W-1:0]  w_root [SQ_STEPS+1];
    t_sq_side        w_side [SQ_STEPS+1];
    logic            w_v    [SQ_STEPS+1];

    assign w_rem[0]  = '0;
    assign w_x[0]    = i_q;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stg
        logic [SR_W-1:0] n_cat;
        logic [SR_W-1:0] n_trial;
        logic            n_ge;
        logic [S_W-1:0]  r_root;
        t_sq_side        r_side;
        logic            r_v;

        assign n_cat   = {w_rem[k][SR_W-3:0], w_x[k][Q_W-1 -: 2]};
        assign n_trial = {w_root[k], 2'b01};
        assign n_ge    = (n_cat >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= {w_root[k][S_W-2:0], n_ge};
                r_side <= w_side[k];
            end
        end

        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
        assign w_v[k+1]    = r_v;

        if (k < SQ_STEPS - 1) begin : g_carry
            logic [SR_W-1:0] r_rem;
            logic [Q_W-1:0]  r_x;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_ge ? (n_cat - n_trial) : n_cat;
                    r_x   <= {w_x[k][Q_W-3:0], 2'b00};
                end
            end

            assign w_rem[k+1] = r_rem;
            assign w_x[k+1]   = r_x;
        end
    end

    assign o_valid = w_v[SQ_STEPS];
    assign o_s     = w_root[SQ_STEPS];
    assign o_side  = w_side[SQ_STEPS];

endmodule

[sv/rsi_div.sv]
module rsi_div
    import rsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [REM_W-1:0]   i_x,
    input  logic [A_W-1:0]     i_d,
    input  t_dv_side           i_side,
    output logic               o_valid,
    output logic [DIST_W-1:0]  o_q,
    output t_dv_side           o_side
);

    // restoring divide, quotient known to fit DIST_W bits when it is used
    logic [REM_W-1:0]  w_rem  [DIV_STEPS];
    logic [A_W-1:0]    w_d    [DIV_STEPS];
    logic [DIST_W-1:0] w_q    [DIV_STEPS+1];
    t_dv_side          w_side [DIV_STEPS+1];
    logic              w_v    [DIV_STEPS+1];

    assign w_rem[0]  = i_x;
    assign w_d[0]    = i_d;
    assign w_q[0]    = '0;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stg
        localparam int SH = DIV_STEPS - 1 - k;
        logic [REM_W-1:0]  n_dsh;
        logic              n_ge;
        logic [DIST_W-1:0] r_q;
        t_dv_side          r_side;
        logic              r_v;

        assign n_dsh = REM_W'(w_d[k]) << SH;
        assign n_ge  = (w_rem[k] >= n_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q    <= {w_q[k][DIST_W-2:0], n_ge};
                r_side <= w_side[k];
            end
        end

        assign w_q[k+1]    = r_q;
        assign w_side[k+1] = r_side;
        assign w_v[k+1]    = r_v;

        if (k < DIV_STEPS - 1) begin : g_carry
            logic [REM_W-1:0] r_rem;
            logic [A_W-1:0]   r_d;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_ge ? (w_rem[k] - n_dsh) : w_rem[k];
                    r_d   <= w_d[k];
                end
            end

            assign w_rem[k+1] = r_rem;
            assign w_d[k+1]   = r_d;
        end
    end

    assign o_valid = w_v[DIV_STEPS];
    assign o_q     = w_q[DIV_STEPS];
    assign o_side  = w_side[DIV_STEPS];

endmodule

[sv/ray_sphere_intersect_unit.sv]
// Ray / sphere hit test in signed Q16.16. Fully pipelined: one ray-sphere pair is taken
// every cycle while o_stall is low. The pipe is made of seven stages that form the exact
// quadratic terms and the discriminant, a 66-stage square root (one root bit per stage),
// three stages that pick the nearest positive root and compare it with nearest_in, a
// 31-stage divider (one distance bit per stage), one stage that selects the new or the
// old distance and the output register. The smallest root whose distance floors to a
// nonzero value is used, so a ray starting inside the sphere hits the far wall; on no
// hit nearest_in comes back unchanged. While the output is stalled the pipe keeps moving
// until a finished result finds the output register full; that result goes to a skid
// entry, o_stall rises on the next cycle and the whole pipe holds until the skid entry
// drains.
module ray_sphere_intersect_unit
    import rsi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [COORD_W-1:0]  i_org_x,
    input  logic signed [COORD_W-1:0]  i_org_y,
    input  logic signed [COORD_W-1:0]  i_org_z,
    input  logic signed [COORD_W-1:0]  i_dir_x,
    input  logic signed [COORD_W-1:0]  i_dir_y,
    input  logic signed [COORD_W-1:0]  i_dir_z,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic signed [COORD_W-1:0]  i_center_z,
    input  logic [DIST_W-1:0]          i_sphere_radius,
    input  logic [DIST_W-1:0]          i_nearest_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_hit,
    output logic [DIST_W-1:0]          o_nearest_out
);

    logic w_en;

    logic signed [COORD_W-1:0] w_org [3];
    logic signed [COORD_W-1:0] w_dir [3];
    logic signed [COORD_W-1:0] w_ctr [3];

    assign w_org = '{i_org_x, i_org_y, i_org_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign w_ctr = '{i_center_x, i_center_y, i_center_z};

    // front valid bits and end valid bits
    logic [6:0] r_vf;
    logic [2:0] r_ve;

    // stage 1
    logic signed [COORD_W-1:0] r1_d [3];
    logic signed [OC_W-1:0]    r1_oc [3];
    logic [DIST_W-1:0]         r1_r;
    logic [DIST_W-1:0]         r1_near;
    // stage 2
    logic [A_W-1:0]            r2_dd [3];
    logic signed [H_W-2:0]     r2_doc [3];
    logic [CABS_W-1:0]         r2_oo [3];
    logic [2*DIST_W-1:0]       r2_rr;
    logic [DIST_W-1:0]         r2_near;
    // stage 3
    logic [A_W-1:0]            r3_a;
    logic signed [H_W-1:0]     r3_h;
    logic signed [C_W-1:0]     r3_c;
    logic [DIST_W-1:0]         r3_near;
    // stage 4
    logic [HABS_W-1:0]         r4_habs;
    logic [CABS_W-1:0]         r4_cabs;
    logic                      r4_cneg;
    logic [A_W-1:0]            r4_a;
    logic signed [H_W-1:0]     r4_h;
    logic [DIST_W-1:0]         r4_near;
    logic [DIST_W+LO_W-1:0]    r4_nal;
    logic [DIST_W+LO_W-1:0]    r4_nah;
    // stage 5: partial products
    logic [2*LO_W-1:0]         r5_hll;
    logic [LO_W+HH_W-1:0]      r5_hlh;
    logic [2*HH_W-1:0]         r5_hhh;
    logic [2*LO_W-1:0]         r5_p0;
    logic [LO_W+CH_W-1:0]      r5_p1;
    logic [2*LO_W-1:0]         r5_p2;
    logic [LO_W+CH_W-1:0]      r5_p3;
    logic                      r5_cneg;
    logic [A_W-1:0]            r5_a;
    logic signed [H_W-1:0]     r5_h;
    logic [NA_W-1:0]           r5_na;
    logic [DIST_W-1:0]         r5_near;
    // stage 6
    logic [P_W-1:0]            r6_h2;
    logic [P_W-1:0]            r6_acm;
    logic                      r6_cneg;
    logic [A_W-1:0]            r6_a;
    logic signed [H_W-1:0]     r6_h;
    logic [NA_W-1:0]           r6_na;
    logic [DIST_W-1:0]         r6_near;
    // stage 7: discriminant
    logic [Q_W-1:0]            n7_q;
    logic [Q_W-1:0]            r7_q;
    t_sq_side                  r7_side;

    // square root outputs
    logic                      w_sq_v;
    logic [S_W-1:0]            w_s;
    t_sq_side                  w_sq_side;

    // root selection
    logic signed [N_W-1:0]     n_hx;
    logic signed [N_W-1:0]     n_sx;
    logic signed [N_W-1:0]     re1_nn;
    logic signed [N_W-1:0]     re1_nf;
    t_sq_side                  re1_side;
    logic                      re2_near_ok;
    logic                      re2_far_ok;
    logic [N_W-2:0]            re2_nn;
    logic [N_W-2:0]            re2_nf;
    t_sq_side                  re2_side;
    logic [REM_W-1:0]          n3_x;
    logic [REM_W-1:0]          re3_x;
    logic [A_W-1:0]            re3_a;
    t_dv_side                  re3_dv;

    // divider outputs
    logic                      w_dv_v;
    logic [DIST_W-1:0]         w_q;
    t_dv_side                  w_dv_side;

    // final and output stages
    logic                      r_fv;
    logic                      r_fhit;
    logic [DIST_W-1:0]         r_fdist;
    logic                      r_ov;
    logic                      r_ohit;
    logic [DIST_W-1:0]         r_odist;
    logic                      r_skid_v;
    logic                      r_shit;
    logic [DIST_W-1:0]         r_sdist;

    // the whole pipe moves unless the skid entry is holding a result
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
            r_ve <= '0;
            r_fv <= 1'b0;
        end else if (w_en) begin
            r_vf <= {r_vf[5:0], i_valid};
            r_ve <= {r_ve[1:0], w_sq_v};
            r_fv <= w_dv_v;
        end
    end

    always_comb begin
        n7_q = r6_cneg ? (Q_W'(r6_h2) + Q_W'(r6_acm)) : (Q_W'(r6_h2) - Q_W'(r6_acm));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k]  <= w_dir[k];
                r1_oc[k] <= OC_W'(w_org[k]) - OC_W'(w_ctr[k]);
            end
            r1_r    <= i_sphere_radius;
            r1_near <= i_nearest_in;

            for (int k = 0; k < 3; k++) begin
                r2_dd[k]  <= r1_d[k] * r1_d[k];
                r2_doc[k] <= r1_d[k] * r1_oc[k];
                r2_oo[k]  <= r1_oc[k] * r1_oc[k];
            end
            r2_rr   <= r1_r * r1_r;
            r2_near <= r1_near;

            r3_a    <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_h    <= r2_doc[0] + r2_doc[1] + r2_doc[2];
            r3_c    <= $signed(C_W'(r2_oo[0]) + C_W'(r2_oo[1]) + C_W'(r2_oo[2])
                               - C_W'(r2_rr));
            r3_near <= r2_near;

            r4_habs <= r3_h[H_W-1] ? HABS_W'(-r3_h) : HABS_W'(r3_h);
            r4_cabs <= r3_c[C_W-1] ? CABS_W'(-r3_c) : CABS_W'(r3_c);
            r4_cneg <= r3_c[C_W-1];
            r4_a    <= r3_a;
            r4_h    <= r3_h;
            r4_near <= r3_near;
            r4_nal  <= r3_near * r3_a[LO_W-1:0];
            r4_nah  <= r3_near * r3_a[A_W-1:LO_W];

            r5_hll  <= r4_habs[LO_W-1:0] * r4_habs[LO_W-1:0];
            r5_hlh  <= r4_habs[LO_W-1:0] * r4_habs[HABS_W-1:LO_W];
            r5_hhh  <= r4_habs[HABS_W-1:LO_W] * r4_habs[HABS_W-1:LO_W];
            r5_p0   <= r4_a[LO_W-1:0] * r4_cabs[LO_W-1:0];
            r5_p1   <= r4_a[LO_W-1:0] * r4_cabs[CABS_W-1:LO_W];
            r5_p2   <= r4_a[A_W-1:LO_W] * r4_cabs[LO_W-1:0];
            r5_p3   <= r4_a[A_W-1:LO_W] * r4_cabs[CABS_W-1:LO_W];
            r5_cneg <= r4_cneg;
            r5_a    <= r4_a;
            r5_h    <= r4_h;
            r5_na   <= NA_W'(r4_nal) + (NA_W'(r4_nah) << LO_W);
            r5_near <= r4_near;

            // cross term of H*H appears twice
            r6_h2   <= P_W'(r5_hll) + (P_W'(r5_hlh) << (LO_W + 1))
                       + (P_W'(r5_hhh) << (2 * LO_W));
            r6_acm  <= P_W'(r5_p0) + ((P_W'(r5_p1) + P_W'(r5_p2)) << LO_W)
                       + (P_W'(r5_p3) << (2 * LO_W));
            r6_cneg <= r5_cneg;
            r6_a    <= r5_a;
            r6_h    <= r5_h;
            r6_na   <= r5_na;
            r6_near <= r5_near;

            r7_q         <= n7_q;
            r7_side.ok   <= (r6_a != '0) && !n7_q[Q_W-1];
            r7_side.h    <= r6_h;
            r7_side.a    <= r6_a;
            r7_side.na   <= r6_na;
            r7_side.near <= r6_near;
        end
    end

    rsi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vf[6]),
        .i_q     (r7_q),
        .i_side  (r7_side),
        .o_valid (w_sq_v),
        .o_s     (w_s),
        .o_side  (w_sq_side)
    );

    assign n_hx = N_W'(w_sq_side.h);
    assign n_sx = $signed(N_W'(w_s));

    // roots -H-S and -H+S; a root counts only if its distance floors to at least one
    always_comb begin
        n3_x = re2_near_ok ? (REM_W'(re2_nn) << FRAC_BITS) : (REM_W'(re2_nf) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            re1_nn   <= -n_hx - n_sx;
            re1_nf   <= -n_hx + n_sx;
            re1_side <= w_sq_side;

            re2_near_ok <= !re1_nn[N_W-1]
                           && ((X_W'(re1_nn[N_W-2:0]) << FRAC_BITS) >= X_W'(re1_side.a));
            re2_far_ok  <= !re1_nf[N_W-1]
                           && ((X_W'(re1_nf[N_W-2:0]) << FRAC_BITS) >= X_W'(re1_side.a));
            re2_nn      <= re1_nn[N_W-2:0];
            re2_nf      <= re1_nf[N_W-2:0];
            re2_side    <= re1_side;

            // hit when N*2^F < nearest_in*A, so the quotient always fits
            re3_x       <= n3_x;
            re3_a       <= re2_side.a;
            re3_dv.hit  <= re2_side.ok && (re2_near_ok || re2_far_ok)
                           && (n3_x < REM_W'(re2_side.na));
            re3_dv.near <= re2_side.near;
        end
    end

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ve[2]),
        .i_x     (re3_x),
        .i_d     (re3_a),
        .i_side  (re3_dv),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_side  (w_dv_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fhit  <= w_dv_side.hit;
            r_fdist <= w_dv_side.hit ? w_q : w_dv_side.near;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (r_fv && r_ov && i_stall) begin
                r_skid_v <= 1'b1;
            end
            if (!r_ov || !i_stall) begin
                r_ov <= r_fv;
            end
        end else if (!i_stall) begin
            r_ov     <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_ov || !i_stall) begin
                r_ohit  <= r_fhit;
                r_odist <= r_fdist;
            end else begin
                r_shit  <= r_fhit;
                r_sdist <= r_fdist;
            end
        end else if (!i_stall) begin
            r_ohit  <= r_shit;
            r_odist <= r_sdist;
        end
    end

    assign o_valid       = r_ov;
    assign o_hit         = r_ohit;
    assign o_nearest_out = r_odist;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid entry full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_ov && !r_skid_v))
        else $error("skid entry did not move to output after transfer");

    a_no_sat_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ohit) |-> (r_odist != DIST_MAX))
        else $error("hit reported with saturated distance");

    a_fill_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fv && r_ov && i_stall && !r_skid_v) |=> r_skid_v)
        else $error("finished result dropped while output stalled");
`endif

endmodule

[dv/ray_sphere_intersect_unit_chk.sv]
module ray_sphere_intersect_unit_chk
    import rsi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_stall_in,
    input  logic signed [COORD_W-1:0]  i_org_x,
    input  logic signed [COORD_W-1:0]  i_org_y,
    input  logic signed [COORD_W-1:0]  i_org_z,
    input  logic signed [COORD_W-1:0]  i_dir_x,
    input  logic signed [COORD_W-1:0]  i_dir_y,
    input  logic signed [COORD_W-1:0]  i_dir_z,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic signed [COORD_W-1:0]  i_center_z,
    input  logic [DIST_W-1:0]          i_sphere_radius,
    input  logic [DIST_W-1:0]          i_nearest_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_hit,
    input  logic [DIST_W-1:0]          i_nearest_out,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_rays,
    output int                         o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] t_swide;
    typedef logic [255:0]        t_uwide;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] dist_out;
    } t_hit_result;

    t_hit_result hit_q[$];

    function automatic t_uwide int_sqrt(t_uwide v);
        t_uwide rem, root, bitv;
        rem  = v;
        root = '0;
        bitv = t_uwide'(1) << 254;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // distance of one root numerator, 0 when not positive
    function automatic logic [DIST_W-1:0] root_distance(t_swide num, t_swide a);
        t_uwide t;
        if (num <= 0)
            return '0;
        t = t_uwide'(num << FRAC_BITS) / t_uwide'(a);
        if (t > t_uwide'(DIST_MAX))
            return DIST_MAX;
        return t[DIST_W-1:0];
    endfunction

    function automatic t_hit_result trace_sphere(
        logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
        logic [DIST_W-1:0] rad, logic [DIST_W-1:0] near);
        t_swide d[3], o[3], c[3], oc, a, h, cc, r, disc, s;
        logic [DIST_W-1:0] t;
        t_hit_result res;
        d[0] = dx; d[1] = dy; d[2] = dz;
        o[0] = ox; o[1] = oy; o[2] = oz;
        c[0] = cx; c[1] = cy; c[2] = cz;
        a = '0; h = '0; cc = '0;
        for (int k = 0; k < 3; k++) begin
            oc = o[k] - c[k];
            a  = a + d[k] * d[k];
            h  = h + d[k] * oc;
            cc = cc + oc * oc;
        end
        r    = t_swide'({1'b0, rad});
        cc   = cc - r * r;
        disc = h * h - a * cc;
        res.hit      = 1'b0;
        res.dist_out = near;
        if (a == 0 || disc < 0)
            return res;
        s = t_swide'(int_sqrt(t_uwide'(disc)));
        t = root_distance(-h - s, a);
        if (t == 0)
            t = root_distance(-h + s, a);
        if (t != 0 && t < near) begin
            res.hit      = 1'b1;
            res.dist_out = t;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_rays   = 0;
        o_hits   = 0;
    end

    assign o_pending = hit_q.size();

    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n && i_valid && !i_stall_in) begin
            want = trace_sphere(i_org_x, i_org_y, i_org_z, i_dir_x, i_dir_y, i_dir_z,
                                i_center_x, i_center_y, i_center_z,
                                i_sphere_radius, i_nearest_in);
            hit_q.push_back(want);
            o_rays++;
            if (want.hit)
                o_hits++;
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (hit_q.size() == 0) begin
                report_mismatch("unexpected transfer", {31'b0, i_hit}, 32'b0);
            end else begin
                want = hit_q.pop_front();
                if (i_hit !== want.hit)
                    report_mismatch("hit", {31'b0, i_hit}, {31'b0, want.hit});
                if (i_nearest_out !== want.dist_out)
                    report_mismatch("nearest_out", {1'b0, i_nearest_out},
                                    {1'b0, want.dist_out});
            end
        end
    end

endmodule

[dv/ray_sphere_intersect_unit_tb.sv]
module ray_sphere_intersect_unit_tb
    import rsi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int N_RANDOM  = 830;
    localparam int HOLD_LEN  = 300;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] org_x = '0, org_y = '0, org_z = '0;
    logic signed [COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [COORD_W-1:0] cen_x = '0, cen_y = '0, cen_z = '0;
    logic [DIST_W-1:0]         radius = '0, near_in = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_hit;
    logic [DIST_W-1:0]         o_nearest_out;

    int  n_errors, n_pending, n_rays, n_hits;
    bit  sending_done = 1'b0;
    bit  hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ray_sphere_intersect_unit i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_org_x(org_x), .i_org_y(org_y), .i_org_z(org_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .i_center_x(cen_x), .i_center_y(cen_y), .i_center_z(cen_z),
        .i_sphere_radius(radius), .i_nearest_in(near_in),
        .o_valid, .i_stall, .o_hit, .o_nearest_out
    );

    ray_sphere_intersect_unit_chk i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_org_x(org_x), .i_org_y(org_y), .i_org_z(org_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .i_center_x(cen_x), .i_center_y(cen_y), .i_center_z(cen_z),
        .i_sphere_radius(radius), .i_nearest_in(near_in),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_hit(o_hit),
        .i_nearest_out(o_nearest_out),
        .o_errors(n_errors), .o_pending(n_pending), .o_rays(n_rays), .o_hits(n_hits)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // one transfer; valid stays high into the next ray when there is no gap
    task automatic send_ray(
        logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
        logic [30:0] rad, logic [30:0] near, bit allow_gap);
        int g;
        i_valid <= 1'b1;
        org_x <= ox; org_y <= oy; org_z <= oz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        cen_x <= cx; cen_y <= cy; cen_z <= cz;
        radius <= rad; near_in <= near;
        do @(posedge i_clk); while (o_stall);
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rnd32();
        return $urandom();
    endfunction

    function automatic logic signed [31:0] rnd_range(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int left;
        bit on;
        left = 0;
        on = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
                left = 0;
            end
            if (left == 0) begin
                on = !on && ($urandom_range(99) < 30);
                left = sending_done ? 1 : gap_len() + 1;
                if ($urandom_range(99) < 5) on = 1'b0;
            end
            i_stall <= on;
            left--;
        end
    end

    initial begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic [30:0] rad, near;
        int k;
        logic [31:0] eq;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, all ones / all zeros
        send_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        send_ray('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, '1, '1, 1'b1);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '1, '1, 1'b0);
        // zero direction
        send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, DIST_W'(5 * ONE), DIST_MAX, 1'b1);
        // plain front hit, and a miss from a negative discriminant
        send_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, DIST_W'(2 * ONE), DIST_MAX, 1'b0);
        send_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, DIST_W'(2 * ONE), DIST_MAX, 1'b1);
        // sphere behind the ray
        send_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, DIST_W'(2 * ONE), DIST_MAX, 1'b1);
        // origin inside: far wall
        send_ray(3 * ONE, ONE, 0, 0, ONE, 0, 3 * ONE, ONE, 0, DIST_W'(5 * ONE), DIST_MAX,
                 1'b1);
        send_ray(0, 0, 0, 0, 0, -ONE / 2, 0, 0, ONE, DIST_W'(5 * ONE), DIST_MAX, 1'b1);
        // tangent, double root
        send_ray(0, 2 * ONE, 0, ONE, 0, 0, 10 * ONE, 0, 0, DIST_W'(2 * ONE), DIST_MAX, 1'b1);
        // tiny direction saturates the distance
        send_ray(0, 0, 0, 1, 0, 0, 1000 * ONE, 0, 0, DIST_W'(ONE), DIST_MAX, 1'b1);
        send_ray(0, 0, 0, 1, 0, 0, 1000 * ONE, 0, 0, DIST_W'(ONE), DIST_MAX - 1, 1'b0);
        // nearer hit already known
        send_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, DIST_W'(2 * ONE), DIST_W'(4 * ONE),
                 1'b1);
        // exactly equal and one above the root distance
        eq = i_chk.trace_sphere(ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, ONE / 3,
                                40 * ONE, 0, 7 * ONE, DIST_W'(9 * ONE), DIST_MAX);
        send_ray(ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, ONE / 3, 40 * ONE, 0, 7 * ONE,
                 DIST_W'(9 * ONE), eq[30:0], 1'b1);
        send_ray(ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, ONE / 3, 40 * ONE, 0, 7 * ONE,
                 DIST_W'(9 * ONE), eq[30:0] + 31'd1, 1'b0);
        // zero radius on the ray line
        send_ray(0, 0, 0, ONE, ONE, 0, 4 * ONE, 4 * ONE, 0, '0, DIST_MAX, 1'b1);
        // root that floors to zero: sphere just touching the origin
        send_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, DIST_W'(ONE), DIST_MAX, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) hold_req = 1'b1;
            k = $urandom_range(99);
            if (k < 15) begin
                ox = rnd32(); oy = rnd32(); oz = rnd32();
                dx = rnd32(); dy = rnd32(); dz = rnd32();
                cx = rnd32(); cy = rnd32(); cz = rnd32();
                rad = DIST_W'($urandom()); near = DIST_W'($urandom());
            end else begin
                // scene: sphere placed near a point along the ray
                ox = rnd_range(1 << 21); oy = rnd_range(1 << 21); oz = rnd_range(1 << 21);
                dx = rnd_range(1 << 17); dy = rnd_range(1 << 17); dz = rnd_range(1 << 17);
                k  = $urandom_range(8, 0) - 1;
                cx = ox + dx * k + rnd_range(1 << 17);
                cy = oy + dy * k + rnd_range(1 << 17);
                cz = oz + dz * k + rnd_range(1 << 17);
                rad = DIST_W'($urandom_range(1 << 19));
                case ($urandom_range(2))
                    0: near = DIST_MAX;
                    1: near = DIST_W'($urandom_range(12 * ONE));
                    default: near = DIST_W'($urandom());
                endcase
            end
            send_ray(ox, oy, oz, dx, dy, dz, cx, cy, cz, rad, near, 1'b1);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;

        while (n_pending != 0 || hold_req) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("rays sent: %0d, nearer hits predicted: %0d", n_rays, n_hits);
        $display("covered zero direction, misses, inside origin, tangent, saturation, ties");
        if (n_errors == 0 && n_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
